[design/binomial_blur_3x3_macros.svh]
// Assertion macros shared by the blur checker.
`ifndef BINOMIAL_BLUR_3X3_MACROS_SVH
`define BINOMIAL_BLUR_3X3_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while arst_n is low.
`define BB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, quiet while arst_n is low.
`define BB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/bblur_pkg.sv]
// Package with the constants, types and kernel arithmetic of the 3x3 binomial blur.
package bblur_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int HEIGHT_CAP = 4096;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int COORD_W    = 13;
	localparam int CC_W       = 3;
	localparam int IDX_W      = 2;

	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH     = 2'd0;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT    = 2'd1;
	localparam logic [IDX_W-1:0] REG_COMPONENT_COUNT = 2'd2;

	localparam logic [COORD_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [COORD_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [CC_W-1:0]    CC_RESET     = 3'd4;
	localparam logic [CC_W-1:0]    CC_FILTER_MIN = 3'd3;

	typedef logic [31:0] pixel_t;
	typedef logic [8:0][31:0] window_t;

	// Per-pixel decisions made when the transaction is taken.
	typedef struct packed {
		logic emit;
		logic filter;
		logic frame_end;
		logic we;
		logic zero_rd;
	} step_ctl_t;

	function automatic logic [11:0] comp12(input pixel_t p, input int k);
		return {4'b0000, p[8*k +: 8]};
	endfunction

	// Kernel 1-2-1 / 2-4-2 / 1-2-1, sum shifted right by four, on the three
	// color components; alpha comes from the center pixel.
	function automatic pixel_t blur_pixel(input window_t w);
		pixel_t      res;
		logic [11:0] s;
		res = w[4];
		for (int k = 0; k < 3; k++) begin
			s = (comp12(w[4], k) << 2)
			  + ((comp12(w[1], k) + comp12(w[3], k) + comp12(w[5], k)
			  + comp12(w[7], k)) << 1)
			  + comp12(w[0], k) + comp12(w[2], k) + comp12(w[6], k) + comp12(w[8], k);
			res[8*k +: 8] = s[11:4];
		end
		return res;
	endfunction

endpackage

[design/binomial_blur_3x3.sv]
// Streaming 3x3 binomial blur with two line stores and a 3x3 window.
//
//  channel  direction  handshake              payload
//  pix      in         pix_valid / pix_stall  red_in green_in blue_in alpha_in drain
//  res      out        res_valid / res_stall  red_out green_out blue_out alpha_out frame_end
//  cfg      in         cfg_we                 cfg_index cfg_data
//
// One transaction is taken per clock while pix_stall is low; the 4096 x 64 line store RAM
// has one read and one write port. It is read at the edge that takes a transaction
// into the read stage, and the result register loads from the read stage when it
// is free. Reset loads the configuration defaults and clears the valid flags, the
// window and the positions but not the line store. While res_stall holds a result,
// at most one more transaction is taken into the read stage, then pix_stall rises.
module binomial_blur_3x3
	import bblur_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	output logic               pix_stall,
	input  logic [7:0]         red_in,
	input  logic [7:0]         green_in,
	input  logic [7:0]         blue_in,
	input  logic [7:0]         alpha_in,
	input  logic               drain,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [7:0]         red_out,
	output logic [7:0]         green_out,
	output logic [7:0]         blue_out,
	output logic [7:0]         alpha_out,
	output logic               frame_end,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [COORD_W-1:0] cfg_data
);

	// Configuration registers.
	logic [COORD_W-1:0] width_q, height_q;
	logic [CC_W-1:0]    ccount_q;

	// Raster position of the next pixel or drain transaction.
	logic [COORD_W-1:0] col_q, row_q;

	// Saturated frame size used for all position arithmetic.
	logic [COORD_W-1:0] w_eff, h_eff;
	logic               draining, step_go, col0;
	logic [COORD_W-1:0] r_eff, ocol, col_inc;
	logic [COORD_W:0]   orow;
	logic               orow_ok, interior;
	step_ctl_t          ctl_d;

	// Read stage.
	logic               valid_s1;
	step_ctl_t          ctl_s1;
	pixel_t             bot_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [63:0]        rd_s1;
	logic               fwd_s1;
	logic [63:0]        fwd_data_s1;

	// Line store: upper row in the high word, middle row in the low word.
	logic [63:0]        line_mem_q [MAX_WIDTH];

	logic               out_free, s1_move, s1_adv;
	logic [63:0]        rd_eff, wr_data;
	logic               wr_en;
	pixel_t             top, mid, value;
	window_t            win_q, win_next;

	logic               res_valid_q, res_end_q;
	pixel_t             res_pix_q;

	// The output register can load when it is empty or being emptied; the read
	// stage moves whenever it is empty or the output register can load.
	assign out_free  = !res_valid_q || !res_stall;
	assign s1_move   = !valid_s1 || out_free;
	assign s1_adv    = valid_s1 && out_free;
	assign pix_stall = !s1_move;

	always_comb begin
		if (width_q == '0)
			w_eff = COORD_W'(1);
		else if (width_q > COORD_W'(MAX_WIDTH))
			w_eff = COORD_W'(MAX_WIDTH);
		else
			w_eff = width_q;
		if (height_q == '0)
			h_eff = COORD_W'(1);
		else if (height_q > COORD_W'(HEIGHT_CAP))
			h_eff = COORD_W'(HEIGHT_CAP);
		else
			h_eff = height_q;
	end

	// Once the row count reaches the frame height only drain transactions
	// count; any transaction of the wrong kind is taken and dropped.
	assign draining = row_q >= h_eff;
	assign step_go  = pix_valid && !pix_stall && (drain == draining);
	assign r_eff    = draining ? h_eff : row_q;
	assign col0     = col_q == '0;
	assign col_inc  = col_q + COORD_W'(1);

	// The pixel leaving the window sits one row and one column behind the
	// input; at the start of a row it is the last pixel of the row above.
	always_comb begin
		if (col0) begin
			orow = {1'b0, r_eff} - (COORD_W+1)'(2);
			ocol = w_eff - COORD_W'(1);
		end else begin
			orow = {1'b0, r_eff} - (COORD_W+1)'(1);
			ocol = col_q - COORD_W'(1);
		end
		orow_ok  = !orow[COORD_W];
		interior = !col0 && orow_ok && (orow[COORD_W-1:0] != '0)
		         && (orow[COORD_W-1:0] < h_eff - COORD_W'(1))
		         && (ocol != '0) && (ocol < w_eff - COORD_W'(1));
		ctl_d.emit      = orow_ok && (orow[COORD_W-1:0] < h_eff) && (ocol < w_eff);
		ctl_d.filter    = interior && (ccount_q >= CC_FILTER_MIN);
		ctl_d.frame_end = (orow[COORD_W-1:0] == h_eff - COORD_W'(1))
		                && (ocol == w_eff - COORD_W'(1));
		ctl_d.we        = !draining && (col_q < COORD_W'(MAX_WIDTH));
		ctl_d.zero_rd   = col_q >= w_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			ccount_q <= CC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_WIDTH:     width_q  <= cfg_data;
				REG_FRAME_HEIGHT:    height_q <= cfg_data;
				REG_COMPONENT_COUNT: ccount_q <= cfg_data[CC_W-1:0];
				default: ;
			endcase
		end
	end

	// Position update. A drain transaction past the row end closes the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step_go) begin
			if (draining) begin
				if (col_q >= w_eff) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= col_inc;
				end
			end else if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= row_q + COORD_W'(1);
			end else begin
				col_q <= col_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_move)
			valid_s1 <= step_go;
	end

	// The write of the pixel in the read stage can land at the same edge as the
	// next read; a matching address then takes the written word instead.
	always_ff @(posedge clk) begin
		if (wr_en)
			line_mem_q[addr_s1] <= wr_data;
		if (step_go) begin
			rd_s1       <= line_mem_q[col_q[ADDR_W-1:0]];
			fwd_s1      <= wr_en && (addr_s1 == col_q[ADDR_W-1:0]);
			fwd_data_s1 <= wr_data;
			ctl_s1      <= ctl_d;
			addr_s1     <= col_q[ADDR_W-1:0];
			bot_s1      <= draining ? '0 : {alpha_in, blue_in, green_in, red_in};
		end
	end

	assign rd_eff  = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign top     = ctl_s1.zero_rd ? '0 : rd_eff[63:32];
	assign mid     = ctl_s1.zero_rd ? '0 : rd_eff[31:0];
	// The middle row moves up and the new pixel becomes the middle row.
	assign wr_en   = s1_adv && ctl_s1.we;
	assign wr_data = {mid, bot_s1};

	// Each window row shifts left; the new column enters on the right.
	always_comb begin
		win_next    = win_q;
		win_next[0] = win_q[1];
		win_next[1] = win_q[2];
		win_next[2] = top;
		win_next[3] = win_q[4];
		win_next[4] = win_q[5];
		win_next[5] = mid;
		win_next[6] = win_q[7];
		win_next[7] = win_q[8];
		win_next[8] = bot_s1;
		// The center after the shift is the old middle-right pixel, which is
		// also the row-end pixel leaving at a row start.
		value = ctl_s1.filter ? blur_pixel(win_next) : win_q[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			win_q <= '0;
		else if (s1_adv)
			win_q <= win_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (out_free)
			res_valid_q <= valid_s1 && ctl_s1.emit;
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			res_pix_q <= value;
			res_end_q <= ctl_s1.frame_end;
		end
	end

	assign res_valid = res_valid_q;
	assign red_out   = res_pix_q[7:0];
	assign green_out = res_pix_q[15:8];
	assign blue_out  = res_pix_q[23:16];
	assign alpha_out = res_pix_q[31:24];
	assign frame_end = res_end_q;

endmodule

[design/bblur_chk.sv]
// Port-level checker for the 3x3 binomial blur, bound to the top level.
`include "binomial_blur_3x3_macros.svh"

module bblur_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       pix_valid,
	input logic       pix_stall,
	input logic       res_valid,
	input logic       res_stall,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic [7:0] alpha_out,
	input logic       frame_end
);

	// A held result stays offered.
	`BB_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped while stalled")

	// A held result keeps its payload.
	`BB_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(red_out) && $stable(green_out) && $stable(blue_out) && $stable(alpha_out) && $stable(frame_end), "result changed while stalled")

	// The input side only stalls behind a result that is held.
	`BB_ASSERT_NOW(a_stall_cause, pix_stall, res_valid && res_stall, "input stalled without output back-pressure")

	// A fresh result follows an input transaction through the read stage.
	`BB_ASSERT_NOW(a_res_source, $rose(res_valid), $past(pix_valid && !pix_stall, 2), "result without a matching input transaction")

endmodule

bind binomial_blur_3x3 bblur_chk u_bblur_chk (.*);

[tb/sv/blur_scoreboard_pkg.sv]
// Scoreboard for the 3x3 binomial blur: predictor state, pending outputs and mismatch count.
`timescale 1ns / 100ps
package blur_tb_pkg;
	import bblur_pkg::*;

	class blur_scoreboard;
		bit [31:0]        upper_row [MAX_WIDTH];
		bit [31:0]        middle_row [MAX_WIDTH];
		bit [31:0]        win [9];
		int               col_pos;
		int               row_pos;
		bit [COORD_W-1:0] width_reg;
		bit [COORD_W-1:0] height_reg;
		bit [CC_W-1:0]    comps_reg;
		// Each entry is {frame_end, alpha, blue, green, red}.
		bit [32:0]        pending_outputs [$];
		int               errors;

		function new();
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			comps_reg  = CC_RESET;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
			case (idx)
				REG_FRAME_WIDTH:     width_reg = val;
				REG_FRAME_HEIGHT:    height_reg = val;
				REG_COMPONENT_COUNT: comps_reg = val[CC_W-1:0];
				default: ;
			endcase
		endfunction

		function int frame_width_used();
			int v;
			v = int'(width_reg);
			return (v < 1) ? 1 : (v > MAX_WIDTH) ? MAX_WIDTH : v;
		endfunction

		function int frame_height_used();
			int v;
			v = int'(height_reg);
			return (v < 1) ? 1 : (v > HEIGHT_CAP) ? HEIGHT_CAP : v;
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction

		// Weighted 3x3 sum of the window on red, green and blue; alpha from the center.
		function bit [31:0] kernel_out();
			bit [31:0]   res;
			bit [7:0]    c [9];
			int unsigned s;
			res = win[4] & 32'hFF00_0000;
			for (int k = 0; k < 3; k++) begin
				for (int j = 0; j < 9; j++)
					c[j] = win[j][8*k +: 8];
				s = 4 * c[4] + 2 * (c[1] + c[3] + c[5] + c[7]) + c[0] + c[2] + c[6] + c[8];
				res[8*k +: 8] = 8'(s >> 4);
			end
			return res;
		endfunction

		// Advances the predictor by one accepted input transaction.
		function void take_pixel(bit is_drain, bit [31:0] px);
			int        w, h, c, r, out_row, out_col;
			bit        draining, interior, at_end;
			bit [31:0] top, mid, bot, prev_right, value;
			w = frame_width_used();
			h = frame_height_used();
			draining = row_pos >= h;
			// A drain inside the frame, or a pixel while draining, is dropped.
			if (is_drain != draining)
				return;
			r = draining ? h : row_pos;
			c = col_pos;
			prev_right = win[5];
			top = '0;
			mid = '0;
			bot = '0;
			if (c < w) begin
				top = upper_row[c];
				mid = middle_row[c];
			end
			if (!draining) begin
				bot = px;
				if (c < MAX_WIDTH) begin
					upper_row[c] = mid;
					middle_row[c] = bot;
				end
			end
			for (int j = 0; j < 9; j += 3) begin
				win[j] = win[j+1];
				win[j+1] = win[j+2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = bot;

			// Column zero finishes the last pixel of the row two rows up.
			if (c == 0) begin
				out_row = r - 2;
				out_col = w - 1;
				value = prev_right;
				interior = 1'b0;
			end else begin
				out_row = r - 1;
				out_col = c - 1;
				value = win[4];
				interior = out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w;
			end
			if (interior && comps_reg >= CC_FILTER_MIN)
				value = kernel_out();
			if (out_row >= 0 && out_row < h && out_col < w) begin
				at_end = out_row == h - 1 && out_col == w - 1;
				pending_outputs.push_back({at_end, value});
			end

			if (draining) begin
				if (c >= w) begin
					col_pos = 0;
					row_pos = 0;
				end else begin
					col_pos = c + 1;
				end
			end else begin
				c++;
				if (c >= w) begin
					c = 0;
					row_pos++;
				end
				col_pos = c;
			end
		endfunction

		task report(string what);
			errors++;
			// Keep the log readable when a broken block mismatches on every pixel.
			if (errors <= 200)
				$display("%0t: mismatch: %s", $time, what);
		endtask

		task compare_field(string name, logic [7:0] got, bit [7:0] want);
			if (got !== want)
				report($sformatf("%s is %h, expected %h", name, got, want));
		endtask

		task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a,
				logic fe);
			bit [32:0] want;
			if (pending_outputs.size() == 0) begin
				report("output transaction with no pixel pending");
				return;
			end
			want = pending_outputs.pop_front();
			compare_field("red_out", r, want[7:0]);
			compare_field("green_out", g, want[15:8]);
			compare_field("blue_out", b, want[23:16]);
			compare_field("alpha_out", a, want[31:24]);
			compare_field("frame_end", {7'd0, fe}, {7'd0, want[32]});
		endtask
	endclass

endpackage

[tb/sv/testbench.sv]
// Top-level testbench: drives pixel frames into the 3x3 binomial blur and checks every output.
`timescale 1ns / 100ps
module testbench;
	import bblur_pkg::*;
	import blur_tb_pkg::*;

	// Cycles with no transaction on either channel before the run is declared hung.
	// The longest legal quiet stretch is the deliberate output hold-off.
	localparam int STALL_LIMIT = 2000;

	logic               clk;
	logic               arst_n;
	logic               pix_valid;
	logic               pix_stall;
	logic [7:0]         red_in;
	logic [7:0]         green_in;
	logic [7:0]         blue_in;
	logic [7:0]         alpha_in;
	logic               drain;
	logic               res_valid;
	logic               res_stall;
	logic [7:0]         red_out;
	logic [7:0]         green_out;
	logic [7:0]         blue_out;
	logic [7:0]         alpha_out;
	logic               frame_end;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [COORD_W-1:0] cfg_data;

	blur_scoreboard sb;

	// Idling controls for the sender and the receiver.
	bit tx_gaps = 1'b1;
	bit rx_gaps = 1'b1;
	bit quiet_tail = 1'b0;
	bit hold_off_req = 1'b0;

	binomial_blur_3x3 dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Both monitors sample right after the edge, so they see the values that the
	// block saw at that edge; all stimulus is driven with nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			sb.take_pixel(drain, {alpha_in, blue_in, green_in, red_in});
		if (arst_n && res_valid && !res_stall)
			sb.check_result(red_out, green_out, blue_out, alpha_out, frame_end);
	end

	// The output side stalls in random bursts, and in large frames holds off for a long
	// stretch so that the block fills up and pushes back on the pixel input.
	initial begin : result_sink
		res_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res_stall <= 1'b1;
				repeat (300) @(posedge clk);
				res_stall <= 1'b0;
			end else if (rx_gaps && !quiet_tail && $urandom_range(0, 5) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Ends the run if no transaction moves on either channel for too long.
	initial begin : watchdog
		int dead_cycles;
		dead_cycles = 0;
		wait (arst_n === 1'b1);
		while (dead_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
				dead_cycles = 0;
			else
				dead_cycles++;
		end
		$display("testbench NOT OK");
		$finish;
	end

	// Offers one input transaction, possibly after a random gap, and returns at the
	// edge where it is taken. The payload holds steady while the block stalls.
	task automatic send_item(input bit is_drain, input bit [31:0] px);
		if (!quiet_tail && tx_gaps && $urandom_range(0, 7) == 0) begin
			pix_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		pix_valid <= 1'b1;
		drain     <= is_drain;
		red_in    <= px[7:0];
		green_in  <= px[15:8];
		blue_in   <= px[23:16];
		alpha_in  <= px[31:24];
		@(posedge clk);
		while (pix_stall) @(posedge clk);
	endtask

	// Sends pixels with random content, then drain transactions. With noise on,
	// stray drains land inside the frame and stray pixels land in the drain; the
	// block must drop both without producing anything.
	task automatic send_stream(input int n_pix, input int n_drain, input bit noisy);
		for (int i = 0; i < n_pix; i++) begin
			if (noisy && $urandom_range(0, 23) == 0)
				send_item(1'b1, $urandom());
			// In a large frame, start the long hold-off a couple of rows in, so
			// the pipeline backs up mid-frame.
			if (!quiet_tail && n_pix >= 384 && i == 150)
				hold_off_req = 1'b1;
			send_item(1'b0, $urandom());
		end
		for (int i = 0; i < n_drain; i++) begin
			if (noisy && $urandom_range(0, 23) == 0)
				send_item(1'b0, $urandom());
			send_item(1'b1, $urandom());
		end
	endtask

	// Lets the block run dry: no input, every pending output delivered, and then a
	// wait for a dropped transaction that may still be in the pipeline.
	task automatic settle();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[COORD_W-1:0];
		@(posedge clk);
		sb.set_reg(idx, value[COORD_W-1:0]);
	endtask

	task automatic set_config(input int w, input int h, input int comps);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_COMPONENT_COUNT, comps);
		cfg_we <= 1'b0;
	endtask

	// One whole frame plus its drain under the given register values; the sizes
	// actually used are the saturated ones.
	task automatic run_frame(input int w, input int h, input int comps, output int n_items);
		int fw, fh;
		settle();
		set_config(w, h, comps);
		fw = sb.frame_width_used();
		fh = sb.frame_height_used();
		tx_gaps = $urandom_range(0, 3) != 0;
		rx_gaps = $urandom_range(0, 3) != 0;
		send_stream(fw * fh, fw + 1, 1'b1);
		n_items = fw * fh + fw + 1;
	endtask

	// Mostly small frames with a random component count, so borders, interiors and
	// pass-through all come up often. The tail of the last batch runs without gaps.
	task automatic random_frames(input int budget, input bit calm_end);
		int done, n, w;
		done = 0;
		while (done < budget) begin
			if (calm_end && done >= budget - 300)
				quiet_tail = 1'b1;
			w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
			run_frame(w, $urandom_range(1, 8), $urandom_range(0, 7), n);
			done += n;
		end
	endtask

	initial begin
		int n;
		sb = new();
		pix_valid <= 1'b0;
		drain     <= 1'b0;
		red_in    <= '0;
		green_in  <= '0;
		blue_in   <= '0;
		alpha_in  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_FRAME_WIDTH;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A 3x3 frame has one interior pixel. Its neighbors are all ones and its
		// own color is full red and blue with no green, which drives the red and blue
		// sums to their top and the green sum to three quarters of it. A drain inside
		// the frame and a pixel during the drain must both be dropped.
		set_config(3, 3, 4);
		for (int i = 0; i < 9; i++) begin
			if (i == 4)
				send_item(1'b1, 32'h0000_0000);
			send_item(1'b0, (i == 4) ? 32'h00FF_00FF : 32'hFFFF_FFFF);
		end
		for (int i = 0; i < 4; i++) begin
			if (i == 2)
				send_item(1'b0, 32'hA5A5_5A5A);
			send_item(1'b1, 32'h0000_0000);
		end

		// Width shrinks from five to three while the frame is paused at column 4
		// of row 2. The next pixel sits beyond the new width, reads nothing from
		// the line stores and wraps the stream to row 3.
		settle();
		set_config(5, 4, 3);
		send_stream(14, 0, 1'b0);
		settle();
		write_reg(REG_FRAME_WIDTH, 3);
		cfg_we <= 1'b0;
		send_stream(4, 4, 1'b0);

		random_frames(750, 1'b0);

		// Size extremes: zero width and height saturate to a single pixel, and a
		// zero height alone gives a single row.
		run_frame(0, 0, 7, n);
		run_frame(3, 0, 0, n);

		// A larger frame during which the output side holds off for a long stretch.
		run_frame(64, 6, 5, n);

		random_frames(750, 1'b1);

		settle();
		if (sb.errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule

[binomial_blur_3x3.f]
+incdir+design
design/bblur_pkg.sv
design/binomial_blur_3x3.sv
design/bblur_chk.sv
tb/sv/blur_scoreboard_pkg.sv
tb/sv/testbench.sv
